// ===== design/pvdx_pkg.sv =====
// ----------------------------------------------------------------------------
// pvdx_pkg
// Shared types, constants and helpers for the pixel pair payload extractor.
// ----------------------------------------------------------------------------
package pvdx_pkg;

    localparam int HEADER_BYTES_DEF = 36;

    localparam logic [7:0] BAND_1_LIMIT = 8'd16;
    localparam logic [7:0] BAND_2_LIMIT = 8'd32;
    localparam logic [7:0] BAND_3_LIMIT = 8'd64;
    localparam logic [7:0] BAND_4_LIMIT = 8'd128;

    localparam logic [2:0] TEX_BITS = 3'd3;

    localparam logic [1:0] LEN_BYTE_0 = 2'd0;
    localparam logic [1:0] LEN_BYTE_1 = 2'd1;
    localparam logic [1:0] LEN_BYTE_2 = 2'd2;
    localparam logic [1:0] LEN_BYTE_3 = 2'd3;

    typedef struct packed {
        logic [7:0] first_red;
        logic [7:0] first_green;
        logic [7:0] first_blue;
        logic [7:0] second_red;
        logic       textured;
        logic       end_of_image;
    } t_pair;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       is_last;
        logic       truncated;
    } t_result;

    // bits carried by a smooth pair for a given red difference
    function automatic logic [2:0] band_bits(input logic [7:0] d);
        logic [2:0] n;
        if (d < BAND_1_LIMIT) begin
            n = 3'd1;
        end else if (d < BAND_2_LIMIT) begin
            n = 3'd2;
        end else if (d < BAND_3_LIMIT) begin
            n = 3'd3;
        end else if (d < BAND_4_LIMIT) begin
            n = 3'd4;
        end else begin
            n = 3'd5;
        end
        return n;
    endfunction

endpackage

// ===== design/pvd_lsb_pixel_pair_extract_unit.sv =====
// ----------------------------------------------------------------------------
// pvd_lsb_pixel_pair_extract_unit
// Extracts a hidden byte stream from pixel pairs, lsb or difference mode.
//
//   channel   direction   handshake               payload
//   pair in   input       i_in_valid/o_in_stall   i_first_*, i_second_red, flags
//   byte out  output      o_out_valid/i_out_stall o_out_byte, o_has_byte, ...
//
// one pair per cycle unless output stalls; results pass in_reg, then out_reg
// a pair that completes no byte and does not end the image gives no result
// pairs after the last byte or end of image are consumed and dropped
// synchronous active-low reset clears all stages and the packing state
// a held result stalls the input stage only when that stage is also full
// ----------------------------------------------------------------------------
module pvd_lsb_pixel_pair_extract_unit #(
    parameter int HEADER_BYTES = pvdx_pkg::HEADER_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_first_red,
    input  logic [7:0] i_first_green,
    input  logic [7:0] i_first_blue,
    input  logic [7:0] i_second_red,
    input  logic       i_textured,
    input  logic       i_end_of_image,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic       o_is_last,
    output logic       o_truncated
);
    import pvdx_pkg::*;

    t_pair   in_pair;
    t_pair   stage_pair;
    t_result core_result;
    t_result out_result;
    logic    advance;
    logic    fire;
    logic    emit;

    assign in_pair.first_red    = i_first_red;
    assign in_pair.first_green  = i_first_green;
    assign in_pair.first_blue   = i_first_blue;
    assign in_pair.second_red   = i_second_red;
    assign in_pair.textured     = i_textured;
    assign in_pair.end_of_image = i_end_of_image;

    pvdx_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_pair    (in_pair),
        .i_advance (advance),
        .o_fire    (fire),
        .o_pair    (stage_pair)
    );

    pvdx_core #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_pair   (stage_pair),
        .o_emit   (emit),
        .o_result (core_result)
    );

    pvdx_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (emit),
        .i_result  (core_result),
        .i_stall   (i_out_stall),
        .o_valid   (o_out_valid),
        .o_result  (out_result),
        .o_advance (advance)
    );

    assign o_out_byte  = out_result.out_byte;
    assign o_has_byte  = out_result.has_byte;
    assign o_is_last   = out_result.is_last;
    assign o_truncated = out_result.truncated;

endmodule

// ===== design/pvdx_in_reg.sv =====
// ----------------------------------------------------------------------------
// pvdx_in_reg
// Input register stage with valid/stall handshake toward the source.
// ----------------------------------------------------------------------------
module pvdx_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  pvdx_pkg::t_pair i_pair,
    input  logic            i_advance,
    output logic            o_fire,
    output pvdx_pkg::t_pair o_pair
);
    import pvdx_pkg::*;

    logic  r_valid;
    t_pair r_pair;
    logic  accept;

    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;
    assign o_fire  = r_valid && i_advance;
    assign o_pair  = r_pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pair <= i_pair;
        end
    end

endmodule

// ===== design/pvdx_core.sv =====
// ----------------------------------------------------------------------------
// pvdx_core
// Bit extraction, byte packing, length capture and end detection.
// ----------------------------------------------------------------------------
module pvdx_core #(
    parameter int HEADER_BYTES = pvdx_pkg::HEADER_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  pvdx_pkg::t_pair   i_pair,
    output logic              o_emit,
    output pvdx_pkg::t_result o_result
);
    import pvdx_pkg::*;

    logic [7:0]  r_acc;
    logic [2:0]  r_pos;
    logic [31:0] r_count;
    logic [31:0] r_len;
    logic        r_done;

    logic [7:0]  diff;
    logic [2:0]  nbits;
    logic [4:0]  mask;
    logic [4:0]  chunk;
    logic [12:0] combined;
    logic [3:0]  total;
    logic        wrap;
    logic [7:0]  byte_val;
    logic [31:0] n_count;
    logic [31:0] n_len;
    logic [32:0] excess;
    logic        hit;
    logic        last;
    logic        trunc;
    logic        work;

    always_comb begin
        diff = (i_pair.first_red >= i_pair.second_red)
             ? (i_pair.first_red - i_pair.second_red)
             : (i_pair.second_red - i_pair.first_red);
        nbits = i_pair.textured ? TEX_BITS : band_bits(diff);
        mask  = 5'((6'd1 << nbits) - 6'd1);
        chunk = i_pair.textured
              ? {2'b00, i_pair.first_blue[0], i_pair.first_green[0], i_pair.first_red[0]}
              : (diff[4:0] & mask);
        combined = {5'b00000, r_acc} | (13'(chunk) << r_pos);
        total    = {1'b0, r_pos} + {1'b0, nbits};
        wrap     = total[3];
        byte_val = combined[7:0];

        n_count = (&r_count) ? r_count : (r_count + 32'd1);

        // length bytes arrive little-endian
        n_len = r_len;
        if (r_count < 32'd4) begin
            case (r_count[1:0])
                LEN_BYTE_0: n_len[7:0]   = byte_val;
                LEN_BYTE_1: n_len[15:8]  = byte_val;
                LEN_BYTE_2: n_len[23:16] = byte_val;
                LEN_BYTE_3: n_len[31:24] = byte_val;
                default:    n_len        = r_len;
            endcase
        end

        // count >= length + header, with header >= 4 covering the length-known test
        excess = {1'b0, n_count} - 33'(HEADER_BYTES);
        hit    = !excess[32] && (excess[31:0] >= n_len);
        last   = wrap && hit;
        trunc  = !last && i_pair.end_of_image;
        work   = i_fire && !r_done;

        o_emit            = work && (wrap || i_pair.end_of_image);
        o_result.out_byte = wrap ? byte_val : 8'd0;
        o_result.has_byte = wrap;
        o_result.is_last  = last;
        o_result.truncated = trunc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= 8'd0;
            r_pos   <= 3'd0;
            r_count <= 32'd0;
            r_len   <= 32'd0;
            r_done  <= 1'b0;
        end else if (work) begin
            r_pos  <= total[2:0];
            r_done <= last || i_pair.end_of_image;
            if (wrap) begin
                r_acc   <= {3'b000, combined[12:8]};
                r_count <= n_count;
                r_len   <= n_len;
            end else begin
                r_acc <= combined[7:0];
            end
        end
    end

endmodule

// ===== design/pvdx_out_reg.sv =====
// ----------------------------------------------------------------------------
// pvdx_out_reg
// Result register stage with valid/stall handshake toward the sink.
// ----------------------------------------------------------------------------
module pvdx_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  pvdx_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_valid,
    output pvdx_pkg::t_result o_result,
    output logic              o_advance
);
    import pvdx_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_advance = !r_valid || !i_stall;
    assign o_valid   = r_valid;
    assign o_result  = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule
